// ===== rtl/core/mexp_pkg.sv =====
`default_nettype none

package mexp_pkg;

  localparam int FIELD_WIDTH           = 32;
  localparam int DEFAULT_OPERAND_WIDTH = 32;
  localparam int REG_INDEX_WIDTH       = 1;

  // Configuration register map.
  typedef enum logic [REG_INDEX_WIDTH-1:0] {
    REG_MODULUS  = 1'b0,
    REG_EXPONENT = 1'b1
  } reg_index_t;

  localparam logic [FIELD_WIDTH-1:0] MODULUS_RESET  = 32'd2;
  localparam logic [FIELD_WIDTH-1:0] EXPONENT_RESET = 32'd1;

endpackage

`default_nettype wire

// ===== rtl/core/mexp_mulmod.sv =====
`default_nettype none

module mexp_mulmod
  import mexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [OPERAND_WIDTH-1:0] a,
  input  logic [OPERAND_WIDTH-1:0] b,
  input  logic [OPERAND_WIDTH-1:0] n,
  output logic                     done,
  output logic [OPERAND_WIDTH-1:0] product
);

  localparam int W  = OPERAND_WIDTH;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  acc;
  logic [W-1:0]  a_reg;
  logic [W-1:0]  b_sh;
  logic [CW-1:0] cnt;
  logic          run;

  logic [W+1:0]  sum;
  logic [W+2:0]  diff1;
  logic [W+2:0]  diff2;
  logic [W-1:0]  acc_next;

  // One multiplier bit per cycle, MSB first: acc = (2*acc + bit*a) mod n.
  // The sum stays below 3n, so subtracting n or 2n always lands in range.
  always_comb begin
    sum   = {1'b0, acc, 1'b0} + (b_sh[W-1] ? {2'b00, a_reg} : {(W + 2){1'b0}});
    diff1 = {1'b0, sum} - {3'b000, n};
    diff2 = {1'b0, sum} - {2'b00, n, 1'b0};
    priority if (!diff2[W+2]) begin
      acc_next = diff2[W-1:0];
    end else if (!diff1[W+2]) begin
      acc_next = diff1[W-1:0];
    end else begin
      acc_next = sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        cnt   <= CW'(W);
        acc   <= '0;
        a_reg <= a;
        b_sh  <= b;
      end else if (run) begin
        acc  <= acc_next;
        b_sh <= {b_sh[W-2:0], 1'b0};
        cnt  <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign product = acc;

endmodule

`default_nettype wire

// ===== rtl/core/modular_exponentiation.sv =====
// The message is first reduced modulo the modulus. Then, for each exponent bit up to its
// highest set bit, lowest bit first, the accumulator is multiplied by the base when the bit
// is set, and the base is squared.
// All multiplications share one bit-serial modular multiplier; one item at a time.
// The done strobe lasts one cycle and cannot be stalled. A modulus below 2 gives 0.
// Synchronous active-high reset sets modulus to 2 and exponent to 1 and idles the block.
`default_nettype none

module modular_exponentiation
  import mexp_pkg::*;
#(
  parameter int OPERAND_WIDTH = DEFAULT_OPERAND_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [FIELD_WIDTH-1:0]     message,
  output logic                       done,
  output logic [FIELD_WIDTH-1:0]     power_result,
  input  logic                       write_enable,
  input  logic [REG_INDEX_WIDTH-1:0] reg_index,
  input  logic [FIELD_WIDTH-1:0]     write_data
);

  localparam int W = OPERAND_WIDTH;

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_BIT,
    S_MUL_ACC,
    S_SQUARE
  } state_t;

  state_t                 state;
  logic [FIELD_WIDTH-1:0] modulus;
  logic [FIELD_WIDTH-1:0] exponent;
  logic [W-1:0]           e_sh;
  logic [W-1:0]           base;
  logic [W-1:0]           acc;
  logic                   mm_start;
  logic [W-1:0]           mm_a;
  logic [W-1:0]           mm_b;
  logic                   mm_done;
  logic [W-1:0]           mm_product;
  logic [W-1:0]           n_w;

  assign n_w  = W'(modulus);
  assign busy = (state != S_IDLE);

  mexp_mulmod #(
    .OPERAND_WIDTH(OPERAND_WIDTH)
  ) u_mulmod (
    .clk    (clk),
    .rst    (rst),
    .start  (mm_start),
    .a      (mm_a),
    .b      (mm_b),
    .n      (n_w),
    .done   (mm_done),
    .product(mm_product)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      modulus  <= MODULUS_RESET;
      exponent <= EXPONENT_RESET;
      mm_start <= 1'b0;
      done     <= 1'b0;
    end else begin
      mm_start <= 1'b0;
      done     <= 1'b0;

      if (write_enable) begin
        unique case (reg_index_t'(reg_index))
          REG_MODULUS:  modulus  <= write_data;
          REG_EXPONENT: exponent <= write_data;
        endcase
      end

      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (n_w < W'(2)) begin
              power_result <= '0;
              done         <= 1'b1;
            end else begin
              // The message is reduced as message * 1 mod n.
              e_sh     <= W'(exponent);
              mm_a     <= W'(1);
              mm_b     <= W'(message);
              mm_start <= 1'b1;
              state    <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mm_done) begin
            base  <= mm_product;
            acc   <= W'(1);
            state <= S_BIT;
          end
        end
        S_BIT: begin
          if (e_sh == '0) begin
            power_result <= FIELD_WIDTH'(acc);
            done         <= 1'b1;
            state        <= S_IDLE;
          end else if (e_sh[0]) begin
            mm_a     <= acc;
            mm_b     <= base;
            mm_start <= 1'b1;
            state    <= S_MUL_ACC;
          end else begin
            mm_a     <= base;
            mm_b     <= base;
            mm_start <= 1'b1;
            state    <= S_SQUARE;
          end
        end
        S_MUL_ACC: begin
          if (mm_done) begin
            acc      <= mm_product;
            mm_a     <= base;
            mm_b     <= base;
            mm_start <= 1'b1;
            state    <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          if (mm_done) begin
            base  <= mm_product;
            e_sh  <= e_sh >> 1;
            state <= S_BIT;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // A result is only delivered as the block returns to idle.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // An accepted item either starts work or answers at once.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy || done))
    else $error("accepted item was dropped");

  // The multiplier only finishes while an item is in flight.
  assert property (@(posedge clk) disable iff (rst) mm_done |-> busy)
    else $error("multiplier finished while idle");

  // Every result for a modulus of at least 2 lies below the modulus.
  assert property (@(posedge clk) disable iff (rst)
    (done && (n_w >= W'(2))) |-> (W'(power_result) < n_w))
    else $error("result not reduced");

endmodule

`default_nettype wire
